// ===== hdl/crc8_frame_receiver_core_assert.svh =====
// Assertion macros shared by the receiver core.
// Each check is clocked on clk and held off while rst_n is low.
`ifndef CRC8_FRAME_RECEIVER_CORE_ASSERT_SVH
`define CRC8_FRAME_RECEIVER_CORE_ASSERT_SVH

// Same-cycle implication.
`define CRC8FR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CRC8FR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/crc8fr_pkg.sv =====
package crc8fr_pkg;

  // Defaults and fixed codes of the receiver
  localparam int MAX_PAYLOAD_DEF = 32;
  localparam int STORE_AW_MAX = 6;

  localparam logic [7:0] CRC_POLY         = 8'h31;
  localparam logic [7:0] CRC_INIT         = 8'hFF;
  localparam logic [7:0] START_MARKER_RST = 8'hAA;
  localparam logic [7:0] HUNT_LIMIT_RST   = 8'd4;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_KIND,
    PH_SIZE,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_READ,
    EM_LOAD
  } emit_state_t;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_TIMEOUT  = 2'd1,
    ST_OVERSIZE = 2'd2,
    ST_CRC_ERR  = 2'd3
  } status_t;

  typedef enum logic {
    CFG_START_MARKER = 1'b0,
    CFG_HUNT_LIMIT   = 1'b1
  } cfg_reg_t;

  // Access request to the payload store
  typedef struct packed {
    logic                    wr_en;
    logic [STORE_AW_MAX-1:0] wr_addr;
    logic [7:0]              wr_data;
    logic                    rd_en;
    logic [STORE_AW_MAX-1:0] rd_addr;
  } store_req_t;

  // CRC-8 over one byte, MSB first
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/crc8fr_payload_store.sv =====
module crc8fr_payload_store #(
  parameter int DEPTH = crc8fr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                   clk,
  input  crc8fr_pkg::store_req_t req,
  output logic [7:0]             rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0] payload_mem_r [DEPTH];
  logic [7:0] rd_data_r;

  // Write one entry per request
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      payload_mem_r[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= payload_mem_r[req.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/crc8_frame_receiver_core.sv =====
// Channel | Handshake              | Payload
// in      | in_valid / in_stall    | in_rx_byte
// out     | out_valid / out_stall  | out_status, out_frame_kind, out_payload_length,
//         |                        | out_byte_index, out_payload_byte, out_has_byte, out_last
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A status result is shown in the next cycle after the byte that ends it is taken.
// A good frame of N payload bytes plays out of the payload memory byte by byte
// (a read and then a load of the output register for each byte, single read port).
// Input is held off while a result waits in the output register or a run plays out.
// Reset is synchronous; the payload memory has no clearing pass.
// out_stall holds the output register and the run sequencer in place.
module crc8_frame_receiver_core #(
  parameter int MAX_PAYLOAD = crc8fr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,

  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_frame_kind,
  output logic [7:0] out_payload_length,
  output logic [4:0] out_byte_index,
  output logic [7:0] out_payload_byte,
  output logic       out_has_byte,
  output logic       out_last,

  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int LW = $clog2(MAX_PAYLOAD + 1);

  // Configuration
  logic [7:0] start_marker_r;
  logic [7:0] hunt_limit_r;

  // Frame state
  crc8fr_pkg::phase_t      phase_r, phase_nxt;
  crc8fr_pkg::emit_state_t emit_state_r, emit_state_nxt;
  logic [7:0]    discard_count_r, discard_count_nxt;
  logic [7:0]    held_kind_r, held_kind_nxt;
  logic [LW-1:0] held_length_r, held_length_nxt;
  logic [LW-1:0] received_count_r, received_count_nxt;
  logic [LW-1:0] emit_idx_r, emit_idx_nxt;
  logic [7:0]    running_crc_r, running_crc_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  crc8fr_pkg::status_t out_status_r, out_status_nxt;
  logic [7:0]          out_frame_kind_r, out_frame_kind_nxt;
  logic [7:0]          out_payload_length_r, out_payload_length_nxt;
  logic [4:0]          out_byte_index_r, out_byte_index_nxt;
  logic [7:0]          out_payload_byte_r, out_payload_byte_nxt;
  logic                out_has_byte_r, out_has_byte_nxt;
  logic                out_last_r, out_last_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic                   is_oversize;
  logic                   body_more;
  logic                   start_emit;
  logic                   res_load;
  crc8fr_pkg::status_t    res_status;
  logic [7:0]             res_kind;
  logic [7:0]             res_length;
  logic                   rd_en;
  logic                   load_byte;
  logic                   emit_last;
  logic [7:0]             discard_inc;
  logic [7:0]             rd_data;
  crc8fr_pkg::store_req_t store_req;

  assign in_stall  = (emit_state_r != crc8fr_pkg::EM_IDLE) || out_valid_r;
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign is_oversize = in_rx_byte > 8'(MAX_PAYLOAD);
  assign body_more   = received_count_r < held_length_r;
  assign discard_inc = discard_count_r + 8'd1;
  assign emit_last   = ((LW+1)'(emit_idx_r) + (LW+1)'(1)) == (LW+1)'(held_length_r);

  // Payload memory
  crc8fr_payload_store #(
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk    (clk),
    .req    (store_req),
    .rd_data(rd_data)
  );

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= crc8fr_pkg::START_MARKER_RST;
      hunt_limit_r   <= crc8fr_pkg::HUNT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (crc8fr_pkg::cfg_reg_t'(cfg_index))
        crc8fr_pkg::CFG_START_MARKER: start_marker_r <= cfg_data;
        crc8fr_pkg::CFG_HUNT_LIMIT:   hunt_limit_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance the receive phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc) begin
      unique case (phase_r)
        crc8fr_pkg::PH_HUNT: begin
          if (in_rx_byte == start_marker_r) phase_nxt = crc8fr_pkg::PH_KIND;
        end
        crc8fr_pkg::PH_KIND: phase_nxt = crc8fr_pkg::PH_SIZE;
        crc8fr_pkg::PH_SIZE: begin
          phase_nxt = is_oversize ? crc8fr_pkg::PH_HUNT : crc8fr_pkg::PH_BODY;
        end
        crc8fr_pkg::PH_BODY: begin
          if (!body_more) phase_nxt = crc8fr_pkg::PH_HUNT;
        end
        default: phase_nxt = crc8fr_pkg::PH_HUNT;
      endcase
    end
  end

  // Frame datapath: CRC, counters, store accesses, status results
  always_comb begin
    discard_count_nxt  = discard_count_r;
    held_kind_nxt      = held_kind_r;
    held_length_nxt    = held_length_r;
    received_count_nxt = received_count_r;
    running_crc_nxt    = running_crc_r;
    start_emit         = 1'b0;
    res_load           = 1'b0;
    res_status         = crc8fr_pkg::ST_GOOD;
    res_kind           = held_kind_r;
    res_length         = 8'(held_length_r);
    store_req.wr_en    = 1'b0;
    store_req.wr_addr  = crc8fr_pkg::STORE_AW_MAX'(received_count_r);
    store_req.wr_data  = in_rx_byte;
    store_req.rd_en    = rd_en;
    store_req.rd_addr  = crc8fr_pkg::STORE_AW_MAX'(emit_idx_r);
    if (in_acc) begin
      unique case (phase_r)
        crc8fr_pkg::PH_HUNT: begin
          if (in_rx_byte == start_marker_r) begin
            discard_count_nxt = 8'd0;
            running_crc_nxt   = crc8fr_pkg::crc8_update(crc8fr_pkg::CRC_INIT, in_rx_byte);
          end else if (discard_inc >= hunt_limit_r) begin
            discard_count_nxt = 8'd0;
            res_load          = 1'b1;
            res_status        = crc8fr_pkg::ST_TIMEOUT;
            res_kind          = 8'd0;
            res_length        = 8'd0;
          end else begin
            discard_count_nxt = discard_inc;
          end
        end
        crc8fr_pkg::PH_KIND: begin
          held_kind_nxt   = in_rx_byte;
          running_crc_nxt = crc8fr_pkg::crc8_update(running_crc_r, in_rx_byte);
        end
        crc8fr_pkg::PH_SIZE: begin
          if (is_oversize) begin
            discard_count_nxt = 8'd0;
            res_load          = 1'b1;
            res_status        = crc8fr_pkg::ST_OVERSIZE;
            res_length        = in_rx_byte;
          end else begin
            held_length_nxt    = in_rx_byte[LW-1:0];
            received_count_nxt = '0;
            running_crc_nxt    = crc8fr_pkg::crc8_update(running_crc_r, in_rx_byte);
          end
        end
        crc8fr_pkg::PH_BODY: begin
          if (body_more) begin
            store_req.wr_en    = 1'b1;
            running_crc_nxt    = crc8fr_pkg::crc8_update(running_crc_r, in_rx_byte);
            received_count_nxt = received_count_r + LW'(1);
          end else begin
            discard_count_nxt = 8'd0;
            if (in_rx_byte != running_crc_r) begin
              res_load   = 1'b1;
              res_status = crc8fr_pkg::ST_CRC_ERR;
            end else if (held_length_r == '0) begin
              res_load   = 1'b1;
              res_status = crc8fr_pkg::ST_GOOD;
            end else begin
              start_emit = 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Advance the run sequencer
  always_comb begin
    emit_state_nxt = emit_state_r;
    unique case (emit_state_r)
      crc8fr_pkg::EM_IDLE: begin
        if (start_emit) emit_state_nxt = crc8fr_pkg::EM_READ;
      end
      crc8fr_pkg::EM_READ: begin
        if (out_free) emit_state_nxt = crc8fr_pkg::EM_LOAD;
      end
      crc8fr_pkg::EM_LOAD: begin
        emit_state_nxt = emit_last ? crc8fr_pkg::EM_IDLE : crc8fr_pkg::EM_READ;
      end
      default: emit_state_nxt = crc8fr_pkg::EM_IDLE;
    endcase
  end

  // Drive the run sequencer outputs
  always_comb begin
    rd_en     = 1'b0;
    load_byte = 1'b0;
    unique case (emit_state_r)
      crc8fr_pkg::EM_IDLE: ;
      crc8fr_pkg::EM_READ: rd_en = out_free;
      crc8fr_pkg::EM_LOAD: load_byte = 1'b1;
      default: ;
    endcase
  end

  // Step the run index
  always_comb begin
    emit_idx_nxt = emit_idx_r;
    if (start_emit) begin
      emit_idx_nxt = '0;
    end else if (load_byte && !emit_last) begin
      emit_idx_nxt = emit_idx_r + LW'(1);
    end
  end

  // Load or drain the output register
  always_comb begin
    out_valid_nxt          = out_valid_r;
    out_status_nxt         = out_status_r;
    out_frame_kind_nxt     = out_frame_kind_r;
    out_payload_length_nxt = out_payload_length_r;
    out_byte_index_nxt     = out_byte_index_r;
    out_payload_byte_nxt   = out_payload_byte_r;
    out_has_byte_nxt       = out_has_byte_r;
    out_last_nxt           = out_last_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (res_load) begin
      out_valid_nxt          = 1'b1;
      out_status_nxt         = res_status;
      out_frame_kind_nxt     = res_kind;
      out_payload_length_nxt = res_length;
      out_byte_index_nxt     = 5'd0;
      out_payload_byte_nxt   = 8'd0;
      out_has_byte_nxt       = 1'b0;
      out_last_nxt           = 1'b1;
    end else if (load_byte) begin
      out_valid_nxt          = 1'b1;
      out_status_nxt         = crc8fr_pkg::ST_GOOD;
      out_frame_kind_nxt     = held_kind_r;
      out_payload_length_nxt = 8'(held_length_r);
      out_byte_index_nxt     = 5'(emit_idx_r);
      out_payload_byte_nxt   = rd_data;
      out_has_byte_nxt       = 1'b1;
      out_last_nxt           = emit_last;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= crc8fr_pkg::PH_HUNT;
      emit_state_r     <= crc8fr_pkg::EM_IDLE;
      discard_count_r  <= 8'd0;
      held_kind_r      <= 8'd0;
      held_length_r    <= '0;
      received_count_r <= '0;
      emit_idx_r       <= '0;
      running_crc_r    <= crc8fr_pkg::CRC_INIT;
      out_valid_r      <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      emit_state_r     <= emit_state_nxt;
      discard_count_r  <= discard_count_nxt;
      held_kind_r      <= held_kind_nxt;
      held_length_r    <= held_length_nxt;
      received_count_r <= received_count_nxt;
      emit_idx_r       <= emit_idx_nxt;
      running_crc_r    <= running_crc_nxt;
      out_valid_r      <= out_valid_nxt;
    end
  end

  // Output payload registers
  always_ff @(posedge clk) begin
    out_status_r         <= out_status_nxt;
    out_frame_kind_r     <= out_frame_kind_nxt;
    out_payload_length_r <= out_payload_length_nxt;
    out_byte_index_r     <= out_byte_index_nxt;
    out_payload_byte_r   <= out_payload_byte_nxt;
    out_has_byte_r       <= out_has_byte_nxt;
    out_last_r           <= out_last_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_frame_kind     = out_frame_kind_r;
  assign out_payload_length = out_payload_length_r;
  assign out_byte_index     = out_byte_index_r;
  assign out_payload_byte   = out_payload_byte_r;
  assign out_has_byte       = out_has_byte_r;
  assign out_last           = out_last_r;

  // Checks
`include "crc8_frame_receiver_core_assert.svh"

  `CRC8FR_ASSERT_NOW(a_rd_in_range, rd_en, emit_idx_r < held_length_r, "store read past frame length")
  `CRC8FR_ASSERT_NOW(a_no_wr_in_run, store_req.wr_en, emit_state_r == crc8fr_pkg::EM_IDLE, "store write during a run")
  `CRC8FR_ASSERT_NEXT(a_run_starts, start_emit, emit_state_r == crc8fr_pkg::EM_READ, "run did not start after good frame")
  `CRC8FR_ASSERT_NOW(a_last_index, out_valid_r && out_has_byte_r && out_last_r, out_byte_index_r == 5'(held_length_r - LW'(1)), "last flag on wrong byte")

endmodule
